FILE: hw/rtl/lsse_pkg.sv
`default_nettype none

package lsse_pkg;

    // Capacity of the color stores unless the top level is given another value.
    localparam int unsigned MAX_LEDS_DEFAULT = 64;

    localparam int unsigned NUM_LEDS_W   = 7;
    localparam int unsigned PERIOD_W     = 16;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned COLOR_W      = 3 * BYTE_W;
    localparam int unsigned BITS_PER_LED = COLOR_W;
    localparam int unsigned BIT_W        = $clog2(BITS_PER_LED);
    localparam int unsigned OPCODE_W     = 2;
    localparam int unsigned CFG_IDX_W    = 2;

    // Register reset values.
    localparam logic [NUM_LEDS_W-1:0] RST_NUM_LEDS    = 7'd8;
    localparam logic [PERIOD_W-1:0]   RST_ZERO_PERIOD = 16'd80;
    localparam logic [PERIOD_W-1:0]   RST_ONE_PERIOD  = 16'd160;

    // Mask of the most significant bit of a color byte.
    localparam logic [BYTE_W-1:0] TOP_BIT = 8'h80;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_SET  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SHOW = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEDS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_PERIOD  = 2'd2;

    // Command queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_DROP = 2'd0,
        CMD_SET  = 2'd1,
        CMD_SHOW = 2'd2,
        CMD_TICK = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [BYTE_W-1:0]   index;
        logic [COLOR_W-1:0]  color;   // red, green, blue from the top bits down
    } cmd_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] zero_period;
        logic [PERIOD_W-1:0] one_period;
    } periods_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lsse_front.sv
`default_nettype none

module lsse_front #(
    parameter int unsigned MAX_LEDS = lsse_pkg::MAX_LEDS_DEFAULT
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire  [lsse_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire  [lsse_pkg::PERIOD_W-1:0]     cfg_wr_data,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [31:0]                       s_tdata,
    input  wire  [lsse_pkg::OPCODE_W-1:0]     s_tuser,
    input  wire                               init_done,
    input  wire                               q_full,
    output logic                              q_push,
    output lsse_pkg::cmd_t                    q_cmd,
    output logic [$clog2(MAX_LEDS+1)-1:0]     led_count,
    output lsse_pkg::periods_t                periods
);
    import lsse_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LEDS + 1);

    logic [NUM_LEDS_W-1:0] num_leds_reg;
    logic [PERIOD_W-1:0]   zero_period_reg;
    logic [PERIOD_W-1:0]   one_period_reg;
    logic [BYTE_W-1:0]     led_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_leds_reg    <= RST_NUM_LEDS;
            zero_period_reg <= RST_ZERO_PERIOD;
            one_period_reg  <= RST_ONE_PERIOD;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_NUM_LEDS:    num_leds_reg    <= cfg_wr_data[NUM_LEDS_W-1:0];
                CFG_ZERO_PERIOD: zero_period_reg <= cfg_wr_data;
                CFG_ONE_PERIOD:  one_period_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // A count above the store capacity behaves as the full capacity.
    always_comb begin
        if (32'(num_leds_reg) > 32'(MAX_LEDS)) begin
            led_count = CNT_W'(MAX_LEDS);
        end else begin
            led_count = CNT_W'(num_leds_reg);
        end
    end

    assign periods.zero_period = zero_period_reg;
    assign periods.one_period  = one_period_reg;

    assign led_index = s_tdata[BYTE_W-1:0];
    assign s_tready  = init_done && !q_full;
    assign q_push    = s_tvalid && s_tready;

    // Sets outside the strip and the unused opcode become drops here, so the
    // back never needs the index range.
    always_comb begin
        q_cmd.index = led_index;
        q_cmd.color = {s_tdata[2*BYTE_W-1:BYTE_W], s_tdata[3*BYTE_W-1:2*BYTE_W],
                       s_tdata[4*BYTE_W-1:3*BYTE_W]};
        case (s_tuser)
            OP_SET: begin
                q_cmd.kind = (32'(led_index) < 32'(led_count)) ? CMD_SET : CMD_DROP;
            end
            OP_SHOW: q_cmd.kind = CMD_SHOW;
            OP_TICK: q_cmd.kind = CMD_TICK;
            default: q_cmd.kind = CMD_DROP;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lsse_queue.sv
`default_nettype none

module lsse_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  lsse_pkg::cmd_t  push_cmd,
    output logic            full,
    input  wire             pop,
    output lsse_pkg::cmd_t  head,
    output logic            empty
);
    import lsse_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lsse_back.sv
`default_nettype none

module lsse_back #(
    parameter int unsigned MAX_LEDS = lsse_pkg::MAX_LEDS_DEFAULT
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire  [$clog2(MAX_LEDS+1)-1:0]     led_count,
    input  lsse_pkg::periods_t                periods,
    input  wire                               q_empty,
    input  lsse_pkg::cmd_t                    q_cmd,
    output logic                              q_pop,
    output logic                              init_done,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [lsse_pkg::PERIOD_W-1:0]     m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    import lsse_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LEDS + 1);
    localparam int unsigned IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR     = 5'b00001,
        ST_IDLE      = 5'b00010,
        ST_COPY_RD   = 5'b00100,
        ST_COPY_WR   = 5'b01000,
        ST_TICK_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    copy_cnt_reg, copy_cnt_next, copy_inc;
    logic                frame_busy_reg, frame_busy_next;
    logic                lead_reg, lead_next;
    logic [CNT_W-1:0]    sym_led_reg, sym_led_next;
    logic [BIT_W-1:0]    sym_bit_reg, sym_bit_next;
    logic [CNT_W-1:0]    frame_leds_reg, frame_leds_next;
    logic [PERIOD_W-1:0] frame_zero_reg, frame_zero_next;
    logic [PERIOD_W-1:0] frame_one_reg, frame_one_next;

    logic                out_valid_reg, out_valid_next;
    logic [PERIOD_W-1:0] out_duty_reg, out_duty_next;
    logic                out_symv_reg, out_symv_next;
    logic                out_last_reg, out_last_next;
    logic                out_acc_reg, out_acc_next;
    logic                out_free;

    logic [COLOR_W-1:0]  led_mem [MAX_LEDS];
    logic [COLOR_W-1:0]  frame_mem [MAX_LEDS];
    logic [COLOR_W-1:0]  led_rdata_reg;
    logic [COLOR_W-1:0]  frame_rdata_reg;
    logic                led_we;
    logic [IDX_W-1:0]    led_waddr;
    logic [COLOR_W-1:0]  led_wdata;
    logic                frame_we;

    logic [BYTE_W-1:0]   sym_byte;
    logic                sym_one;

    // Color store: cleared after reset, written by sets, read by the copy.
    always_ff @(posedge aclk) begin
        if (led_we) begin
            led_mem[led_waddr] <= led_wdata;
        end
        led_rdata_reg <= led_mem[copy_cnt_reg[IDX_W-1:0]];
    end

    // Frame store: filled by the copy, read at the LED being sent.
    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[copy_cnt_reg[IDX_W-1:0]] <= led_rdata_reg;
        end
        frame_rdata_reg <= frame_mem[sym_led_reg[IDX_W-1:0]];
    end

    // Colors are stored red, green, blue from the top; bits go out green first.
    always_comb begin
        case (sym_bit_reg[BIT_W-1:3])
            2'd0:    sym_byte = frame_rdata_reg[2*BYTE_W-1:BYTE_W];
            2'd1:    sym_byte = frame_rdata_reg[3*BYTE_W-1:2*BYTE_W];
            default: sym_byte = frame_rdata_reg[BYTE_W-1:0];
        endcase
        sym_one = |(sym_byte & (TOP_BIT >> sym_bit_reg[2:0]));
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign copy_inc  = copy_cnt_reg + CNT_W'(1);
    assign init_done = (state_reg != ST_CLEAR);

    always_comb begin
        state_next      = state_reg;
        copy_cnt_next   = copy_cnt_reg;
        frame_busy_next = frame_busy_reg;
        lead_next       = lead_reg;
        sym_led_next    = sym_led_reg;
        sym_bit_next    = sym_bit_reg;
        frame_leds_next = frame_leds_reg;
        frame_zero_next = frame_zero_reg;
        frame_one_next  = frame_one_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_duty_next   = out_duty_reg;
        out_symv_next   = out_symv_reg;
        out_last_next   = out_last_reg;
        out_acc_next    = out_acc_reg;
        q_pop           = 1'b0;
        led_we          = 1'b0;
        led_waddr       = copy_cnt_reg[IDX_W-1:0];
        led_wdata       = '0;
        frame_we        = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                led_we = 1'b1;
                if (copy_cnt_reg == CNT_W'(MAX_LEDS - 1)) begin
                    copy_cnt_next = '0;
                    state_next    = ST_IDLE;
                end else begin
                    copy_cnt_next = copy_inc;
                end
            end

            ST_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop         = 1'b1;
                    out_duty_next = '0;
                    out_symv_next = 1'b0;
                    out_last_next = 1'b0;
                    out_acc_next  = 1'b0;
                    case (q_cmd.kind)
                        CMD_SET: begin
                            led_we         = 1'b1;
                            led_waddr      = IDX_W'(q_cmd.index);
                            led_wdata      = q_cmd.color;
                            out_valid_next = 1'b1;
                            out_acc_next   = 1'b1;
                        end
                        CMD_SHOW: begin
                            out_valid_next = 1'b1;
                            if (!frame_busy_reg) begin
                                out_acc_next    = 1'b1;
                                frame_busy_next = 1'b1;
                                frame_leds_next = led_count;
                                frame_zero_next = periods.zero_period;
                                frame_one_next  = periods.one_period;
                                lead_next       = 1'b1;
                                sym_led_next    = '0;
                                sym_bit_next    = '0;
                                copy_cnt_next   = '0;
                                if (led_count != '0) begin
                                    state_next = ST_COPY_RD;
                                end
                            end
                        end
                        CMD_TICK: begin
                            if (frame_busy_reg) begin
                                state_next = ST_TICK_EMIT;
                            end else begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end

            ST_COPY_WR: begin
                frame_we = 1'b1;
                if (copy_inc == frame_leds_reg) begin
                    copy_cnt_next = '0;
                    state_next    = ST_IDLE;
                end else begin
                    copy_cnt_next = copy_inc;
                    state_next    = ST_COPY_RD;
                end
            end

            ST_TICK_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_symv_next  = 1'b1;
                    out_acc_next   = 1'b1;
                    out_duty_next  = '0;
                    out_last_next  = 1'b0;
                    state_next     = ST_IDLE;
                    if (lead_reg) begin
                        lead_next = 1'b0;
                    end else if (sym_led_reg < frame_leds_reg) begin
                        out_duty_next = sym_one ? frame_one_reg : frame_zero_reg;
                        if (sym_bit_reg == BIT_W'(BITS_PER_LED - 1)) begin
                            sym_bit_next = '0;
                            sym_led_next = sym_led_reg + CNT_W'(1);
                        end else begin
                            sym_bit_next = sym_bit_reg + BIT_W'(1);
                        end
                    end else begin
                        out_last_next   = 1'b1;
                        frame_busy_next = 1'b0;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            copy_cnt_reg   <= '0;
            frame_busy_reg <= 1'b0;
            lead_reg       <= 1'b0;
            sym_led_reg    <= '0;
            sym_bit_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            copy_cnt_reg   <= copy_cnt_next;
            frame_busy_reg <= frame_busy_next;
            lead_reg       <= lead_next;
            sym_led_reg    <= sym_led_next;
            sym_bit_reg    <= sym_bit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_leds_reg <= frame_leds_next;
        frame_zero_reg <= frame_zero_next;
        frame_one_reg  <= frame_one_next;
        out_duty_reg   <= out_duty_next;
        out_symv_reg   <= out_symv_next;
        out_last_reg   <= out_last_next;
        out_acc_reg    <= out_acc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_duty_reg;
    assign m_tuser  = {out_acc_reg, out_symv_reg};
    assign m_tlast  = out_last_reg;

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE)
        else $error("command taken from the queue outside the idle state");

    a_copy_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY_RD || state_reg == ST_COPY_WR) |-> frame_busy_reg)
        else $error("frame copy running without an active frame");

    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COPY_WR |-> copy_cnt_reg < frame_leds_reg)
        else $error("frame copy beyond the latched LED count");

    a_tick_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TICK_EMIT |-> frame_busy_reg)
        else $error("symbol emitted without an active frame");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK_EMIT && out_free && out_last_next) |=> !frame_busy_reg)
        else $error("frame still active after its trailing symbol");

endmodule

`default_nettype wire

FILE: hw/rtl/led_strip_symbol_encoder.sv
// Path: a set, a show, a dropped item or a tick outside a frame goes through the command
// queue and the result register; a tick in a frame also passes the tick-emit state.
// Throughput: one set or dropped item per cycle while results are taken; a frame's tick
// holds the executing side while it emits, a show that starts a frame while it copies N LEDs
// (one store port each). Reset (aresetn low, synchronous) restores the registers and then
// clears the color store, during which s_tready stays low; configuration writes are taken.
`default_nettype none

module led_strip_symbol_encoder #(
    parameter int unsigned MAX_LEDS = lsse_pkg::MAX_LEDS_DEFAULT
) (
    input  wire                              aclk,
    input  wire                              aresetn,

    // Configuration writes: 0 LED count, 1 zero period, 2 one period.
    input  wire                              cfg_wr_en,
    input  wire  [lsse_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire  [lsse_pkg::PERIOD_W-1:0]    cfg_wr_data,

    // Item input channel.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [31:0]                      s_tdata,   // led_index, red, green, blue
    input  wire  [lsse_pkg::OPCODE_W-1:0]    s_tuser,   // opcode

    // Result channel.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [lsse_pkg::PERIOD_W-1:0]    m_tdata,   // duty
    output logic [1:0]                       m_tuser,   // symbol_valid, accepted
    output logic                             m_tlast    // last_symbol
);
    import lsse_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LEDS + 1);

    // The front holds the configuration registers and turns each transfer into a
    // command. Sets outside the strip and unknown opcodes are marked as drops so
    // that the back only emits an all-zero result for them.
    logic             init_done;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    cmd_t             push_cmd;
    cmd_t             head_cmd;
    logic [CNT_W-1:0] led_count;
    periods_t         periods;

    lsse_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .init_done    (init_done),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd),
        .led_count    (led_count),
        .periods      (periods)
    );

    // A two-entry command queue lets the front keep taking transfers while the
    // back is busy copying a frame or waits for the result register to drain.
    lsse_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty)
    );

    // The back owns both color stores, the frame sequencer and the result register.
    // A show copies the live colors into the frame store LED by LED, each through a
    // read and a write state; each tick then reads the LED being sent and picks the
    // period for the current bit, after one leading and before one trailing zero symbol.
    lsse_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .led_count (led_count),
        .periods   (periods),
        .q_empty   (q_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import lsse_pkg::*;

    // The bench assumes the block keeps its default capacity.
    localparam int unsigned CAPACITY    = MAX_LEDS_DEFAULT;
    localparam int unsigned LED_IDX_W   = $clog2(CAPACITY);
    // A full-size frame, the color-store clearing pass and the random stalls on
    // both sides fit many times over into this budget.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // A show keeps the back end busy copying the frame after its result has
    // left, so wait out that copy before touching the registers.
    localparam int unsigned DRAIN_WAIT  = 2 * CAPACITY + 8;
    localparam int unsigned PHASE_ITEMS = 40;
    localparam int unsigned NUM_PHASES  = 9;
    localparam int unsigned MAX_REPORTS = 10;

    // The package names three opcodes; the fourth encoding must be ignored.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [PERIOD_W-1:0] duty;
        logic                symbol_valid;
        logic                last_symbol;
        logic                accepted;
    } symbol_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One line of the directed table: either a register write or an input
    // item, optionally with a hand-written expected result.
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [PERIOD_W-1:0]  reg_value;
        logic [OPCODE_W-1:0]  opcode;
        logic [31:0]          data;
        logic                 typed;
        symbol_result_t       want;
    } stim_row_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [PERIOD_W-1:0]  cfg_wr_data  = '0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata      = '0;   // led_index, red, green, blue
    logic [OPCODE_W-1:0]  s_tuser      = '0;   // opcode
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [PERIOD_W-1:0]  m_tdata;             // duty
    logic [1:0]           m_tuser;             // symbol_valid, accepted
    logic                 m_tlast;             // last_symbol

    // Shadow copy of the block: registers, color stores and frame progress.
    logic [NUM_LEDS_W-1:0] reg_num_leds;
    logic [PERIOD_W-1:0]   reg_zero_period;
    logic [PERIOD_W-1:0]   reg_one_period;
    logic [COLOR_W-1:0]    led_rgb   [CAPACITY];
    logic [COLOR_W-1:0]    frame_rgb [CAPACITY];
    logic                  frame_running;
    int unsigned           slot_pos;
    int unsigned           frame_led_count;
    logic [PERIOD_W-1:0]   frame_zero_period;
    logic [PERIOD_W-1:0]   frame_one_period;

    // Results still owed by the block, oldest first.
    symbol_result_t pending_symbols[$];
    stim_row_t      directed_rows[$];

    int unsigned mismatch_count = 0;
    int unsigned transfer_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned snk_idle_pct   = 0;

    led_strip_symbol_encoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    always #5 aclk = ~aclk;

    // A LED count above the store capacity behaves as the capacity.
    function automatic int unsigned leds_in_use();
        int unsigned n;
        n = 32'(reg_num_leds);
        return (n > CAPACITY) ? CAPACITY : n;
    endfunction

    // Advances the shadow state by one accepted item and returns the result
    // the block must produce for it.
    function automatic symbol_result_t predict_item(logic [OPCODE_W-1:0] opcode,
                                                    logic [31:0] data);
        symbol_result_t      res;
        int unsigned         nbits;
        int unsigned         k;
        logic [COLOR_W-1:0]  rgb;
        logic [BYTE_W-1:0]   byte_val;
        res = '0;
        case (opcode)
            OP_SET: begin
                if (32'(data[7:0]) < leds_in_use()) begin
                    // Stored as red, green, blue from the top bits down.
                    led_rgb[data[LED_IDX_W-1:0]] = {data[15:8], data[23:16], data[31:24]};
                    res.accepted = 1'b1;
                end
            end
            OP_SHOW: begin
                if (!frame_running) begin
                    frame_led_count = leds_in_use();
                    for (int i = 0; i < frame_led_count; i++)
                        frame_rgb[LED_IDX_W'(i)] = led_rgb[LED_IDX_W'(i)];
                    frame_zero_period = reg_zero_period;
                    frame_one_period  = reg_one_period;
                    slot_pos          = 0;
                    frame_running     = 1'b1;
                    res.accepted      = 1'b1;
                end
            end
            OP_TICK: begin
                if (frame_running) begin
                    nbits = frame_led_count * BITS_PER_LED;
                    res.symbol_valid = 1'b1;
                    res.accepted     = 1'b1;
                    if (slot_pos > nbits) begin
                        // Trailing zero symbol closes the frame.
                        res.last_symbol = 1'b1;
                        frame_running   = 1'b0;
                        slot_pos        = 0;
                    end else begin
                        // Slot zero is the leading zero symbol; the rest walk
                        // green, red, blue of each LED, top bit first.
                        if (slot_pos != 0) begin
                            k   = slot_pos - 1;
                            rgb = frame_rgb[LED_IDX_W'(k / BITS_PER_LED)];
                            case ((k % BITS_PER_LED) / BYTE_W)
                                0: byte_val = rgb[15:8];
                                1: byte_val = rgb[23:16];
                                default: byte_val = rgb[7:0];
                            endcase
                            res.duty = byte_val[3'(BYTE_W - 1 - (k % BYTE_W))] ?
                                       frame_one_period : frame_zero_period;
                        end
                        slot_pos++;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void cfg_row(logic [CFG_IDX_W-1:0] index,
                                    logic [PERIOD_W-1:0] value);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.reg_index = index;
        row.reg_value = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void item_row(logic [OPCODE_W-1:0] opcode, logic [7:0] led,
                                     logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic typed, logic [PERIOD_W-1:0] duty,
                                     logic valid, logic last, logic acc);
        stim_row_t row;
        row        = '0;
        row.kind   = ROW_ITEM;
        row.opcode = opcode;
        row.data   = {b, g, r, led};
        row.typed  = typed;
        row.want   = {duty, valid, last, acc};
        directed_rows.push_back(row);
    endfunction

    // Offers one item on the input channel, with a random hold-off first, and
    // records the expected result once the transfer has happened. The valid
    // stays high on return so that back-to-back items need no extra edge.
    task automatic send_item(logic [OPCODE_W-1:0] opcode, logic [31:0] data,
                             logic typed, symbol_result_t want);
        symbol_result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opcode;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_item(opcode, data);
        pending_symbols.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_noise();
        logic [OPCODE_W-1:0] op_pick;
        op_pick = OPCODE_W'($urandom_range(0, 3));
        send_item(op_pick, $urandom(), 1'b0, '0);
    endtask

    // Holds the input channel quiet until every owed result has been seen and
    // the back end has had time to finish any copy it is still doing.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [PERIOD_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        case (index)
            CFG_NUM_LEDS:    reg_num_leds    = value[NUM_LEDS_W-1:0];
            CFG_ZERO_PERIOD: reg_zero_period = value;
            CFG_ONE_PERIOD:  reg_one_period  = value;
            default: begin
            end
        endcase
    endtask

    // Result side: every transfer is compared with the oldest expectation.
    // The ready is re-rolled every cycle from the current stall rate.
    always @(posedge aclk) begin
        symbol_result_t got;
        symbol_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            transfer_count++;
            if (pending_symbols.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display(
                        "transfer %0d unexpected: duty %0d valid %b last %b accepted %b",
                        transfer_count, got.duty, got.symbol_valid,
                        got.last_symbol, got.accepted);
            end else begin
                want = pending_symbols.pop_front();
                if (got.duty !== want.duty || got.symbol_valid !== want.symbol_valid ||
                    got.last_symbol !== want.last_symbol ||
                    got.accepted !== want.accepted) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display(
                            "#%0d duty %0d/%0d valid %b/%b last %b/%b acc %b/%b (exp/act)",
                            transfer_count, want.duty, got.duty,
                            want.symbol_valid, got.symbol_valid,
                            want.last_symbol, got.last_symbol,
                            want.accepted, got.accepted);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned         n_led;
        int unsigned         n_set;
        int unsigned         led_pick;
        int unsigned         ticks_left;
        int unsigned         phase_start;
        int unsigned         budget;
        int unsigned         nl;
        logic [PERIOD_W-1:0] zero_val;
        logic [PERIOD_W-1:0] one_val;
        logic [31:0]         data_word;
        logic                first_seq;

        // Shadow state after reset; the frame latches start out as zero.
        reg_num_leds      = RST_NUM_LEDS;
        reg_zero_period   = RST_ZERO_PERIOD;
        reg_one_period    = RST_ONE_PERIOD;
        foreach (led_rgb[i]) begin
            led_rgb[i]   = '0;
            frame_rgb[i] = '0;
        end
        frame_running     = 1'b0;
        slot_pos          = 0;
        frame_led_count   = 0;
        frame_zero_period = '0;
        frame_one_period  = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table. Rows with a hand-written result are the ones whose
        // answer is obvious from the spec; the rest go through the predictor.
        // Reset values first: a tick with no frame and the unused opcode give
        // all-zero results, and the default count of eight LEDs bounds a set.
        item_row(OP_TICK,   8'h00, 8'h00, 8'h00, 8'h00, 1, 16'd0, 0, 0, 0);
        item_row(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 16'd0, 0, 0, 0);
        item_row(OP_SET,    8'd7,  8'h00, 8'hFF, 8'h00, 1, 16'd0, 0, 0, 1);
        item_row(OP_SET,    8'd8,  8'hFF, 8'hFF, 8'hFF, 1, 16'd0, 0, 0, 0);
        item_row(OP_SET,    8'hFF, 8'hFF, 8'h00, 8'hFF, 1, 16'd0, 0, 0, 0);
        item_row(OP_SET,    8'd0,  8'hFF, 8'hA5, 8'h00, 1, 16'd0, 0, 0, 1);
        // Zero LEDs: a frame of just the leading and trailing zero symbols.
        // A second show while it runs is refused.
        cfg_row(CFG_NUM_LEDS, 16'd0);
        item_row(OP_SHOW,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 0, 0, 1);
        item_row(OP_SHOW,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 0, 0, 0);
        item_row(OP_TICK,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 1, 0, 1);
        item_row(OP_TICK,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 1, 1, 1);
        item_row(OP_TICK,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 0, 0, 0);
        // Full capacity: the top LED is writable, one past it is not.
        cfg_row(CFG_NUM_LEDS, 16'd64);
        item_row(OP_SET,    8'd63, 8'hFF, 8'hFF, 8'hFF, 1, 16'd0, 0, 0, 1);
        item_row(OP_SET,    8'd64, 8'hFF, 8'hFF, 8'hFF, 1, 16'd0, 0, 0, 0);
        // One LED with green 0xA5 under the reset periods: the first data
        // symbols are one, zero, one. Changing the periods mid-frame and
        // rewriting the LED must not disturb the running frame.
        cfg_row(CFG_NUM_LEDS, 16'd1);
        item_row(OP_SHOW,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 0, 0, 1);
        item_row(OP_SHOW,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 0, 0, 0);
        item_row(OP_TICK,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 1, 0, 1);
        item_row(OP_TICK,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd160, 1, 0, 1);
        cfg_row(CFG_ZERO_PERIOD, 16'd0);
        cfg_row(CFG_ONE_PERIOD, 16'hFFFF);
        item_row(OP_TICK,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd80, 1, 0, 1);
        item_row(OP_TICK,   8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd160, 1, 0, 1);
        item_row(OP_SET,    8'd0,  8'h00, 8'h00, 8'h00, 1, 16'd0, 0, 0, 1);
        item_row(OP_TICK,   8'd0,  8'h00, 8'h00, 8'h00, 0, 16'd0, 0, 0, 0);
        // A count above capacity acts as the capacity.
        cfg_row(CFG_NUM_LEDS, 16'd127);
        item_row(OP_SET,    8'd63, 8'h12, 8'h34, 8'h56, 1, 16'd0, 0, 0, 1);
        item_row(OP_SET,    8'd64, 8'h12, 8'h34, 8'h56, 1, 16'd0, 0, 0, 0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_item(directed_rows[i].opcode, directed_rows[i].data,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases. Each one starts with the input side paused until
        // every owed result has come back, then loads a fresh register set.
        // A frame left running across the boundary checks that new settings
        // only take hold at the next show.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // The capacity phase must start a fresh frame, so close any old one.
            if (ph == 1) begin
                while (frame_running) send_item(OP_TICK, $urandom(), 1'b0, '0);
            end
            drain_results();

            case (ph / 3)
                0: begin
                    src_idle_pct = 30;
                    snk_idle_pct = 46;
                end
                1: begin
                    src_idle_pct = 46;
                    snk_idle_pct = 30;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase

            case (ph)
                0: begin
                    nl       = 2;
                    zero_val = 16'h0000;
                    one_val  = 16'hFFFF;
                end
                1: begin
                    nl       = 127;
                    zero_val = 16'hFFFF;
                    one_val  = 16'h0000;
                end
                2: begin
                    nl       = 0;
                    zero_val = PERIOD_W'($urandom());
                    one_val  = PERIOD_W'($urandom());
                end
                default: begin
                    nl       = $urandom_range(1, 6);
                    zero_val = PERIOD_W'($urandom());
                    one_val  = PERIOD_W'($urandom());
                end
            endcase
            write_reg(CFG_NUM_LEDS, PERIOD_W'(nl));
            write_reg(CFG_ZERO_PERIOD, zero_val);
            write_reg(CFG_ONE_PERIOD, one_val);

            // The capacity phase runs one full 64-LED frame and stops there.
            budget      = (ph == 1) ? 1 : PHASE_ITEMS;
            phase_start = items_sent;
            first_seq   = 1'b1;
            while (items_sent - phase_start < budget) begin
                if (first_seq || $urandom_range(0, 99) < 75) begin
                    // Well-formed frame: a few color writes (rarely out of
                    // range), a show, then ticks to the trailing symbol with a
                    // little stray traffic mixed in.
                    n_led = leds_in_use();
                    n_set = $urandom_range(0, (n_led < 6) ? n_led + 1 : 6);
                    repeat (n_set) begin
                        if (n_led == 0 || $urandom_range(0, 9) == 0)
                            led_pick = $urandom_range(n_led, 255);
                        else
                            led_pick = $urandom_range(0, n_led - 1);
                        data_word       = $urandom();
                        data_word[7:0]  = led_pick[7:0];
                        send_item(OP_SET, data_word, 1'b0, '0);
                    end
                    send_item(OP_SHOW, $urandom(), 1'b0, '0);
                    ticks_left = frame_running ?
                                 frame_led_count * BITS_PER_LED + 2 - slot_pos : 0;
                    repeat (ticks_left + $urandom_range(0, 2)) begin
                        if ($urandom_range(0, 19) == 0)
                            send_noise();
                        send_item(OP_TICK, $urandom(), 1'b0, '0);
                    end
                end else begin
                    send_noise();
                end
                first_seq = 1'b0;
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: led_strip_symbol_encoder.f
hw/rtl/lsse_pkg.sv
hw/rtl/lsse_front.sv
hw/rtl/lsse_queue.sv
hw/rtl/lsse_back.sv
hw/rtl/led_strip_symbol_encoder.sv
bench/tb.sv
